// ----- rtl/wlc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Weighted least-connections picker package
// Word types, register indexes, operation and status codes shared by the
// picker RTL.
// ----------------------------------------------------------------------------
package wlc_pkg;

  localparam int DEF_SERVERS    = 4;
  localparam int DEF_COUNT_BITS = 16;

  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 8;
  localparam int SC_W        = 3;
  localparam int WEIGHT_W    = 8;
  localparam int WEIGHT_REGS = 4;
  localparam int SRV_W       = 2;
  localparam int CONN_W      = 16;
  localparam int STATUS_W    = 2;

  localparam logic [CFG_IDX_W-1:0] REG_SERVER_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_0     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_LAST  = 3'd4;

  localparam logic OP_OPEN  = 1'b0;
  localparam logic OP_CLOSE = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_IDLE_ERR  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_SATURATED = 2'd2;

  typedef struct packed {
    logic             op;
    logic [SRV_W-1:0] server_index;
  } req_word_t;

  typedef struct packed {
    logic [SRV_W-1:0]    server;
    logic [CONN_W-1:0]   connections;
    logic [STATUS_W-1:0] status;
  } rsp_word_t;

endpackage

// ----- rtl/weighted_least_connections_picker_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Weighted least-connections picker
// Tracks active connections per server and picks the server with the lowest
// connections/weight ratio on open, using one shared cross-product multiplier.
// ----------------------------------------------------------------------------
//  Port   | Dir | Handshake            | Word
//  req    | in  | req_valid/req_ready  | op, server_index
//  rsp    | out | rsp_valid/rsp_ready  | server, connections, status
//  cfg    | in  | cfg_we (no wait)     | cfg_index, cfg_data
//
// A close goes from accept through S_UPD and S_DONE back to S_IDLE; an open
// first steps through S_LHS, S_RHS and S_CMP for each taking-part server
// after the first, on the one shared multiplier (two products and a compare).
// The response word is valid from the cycle in which the block is ready again.
// Reset clears all connection counts, sets four servers and all weights to one.
// A word waits in the output register while the next request is worked on;
// that request then holds in its last step, and no new request is taken,
// until the waiting word leaves.
module weighted_least_connections_picker_unit #(
  parameter int SERVERS    = wlc_pkg::DEF_SERVERS,
  parameter int COUNT_BITS = wlc_pkg::DEF_COUNT_BITS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           req_valid,
  output logic                           req_ready,
  input  wlc_pkg::req_word_t             req,
  output logic                           rsp_valid,
  input  logic                           rsp_ready,
  output wlc_pkg::rsp_word_t             rsp,
  input  logic                           cfg_we,
  input  logic [wlc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [wlc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import wlc_pkg::*;

  localparam int IDX_W  = $clog2(SERVERS);
  localparam int N_W    = $clog2(SERVERS + 1);
  localparam int WIDE_W = N_W + 2;
  localparam int WREG_N = (SERVERS < WEIGHT_REGS) ? SERVERS : WEIGHT_REGS;
  localparam int WI_W   = (WREG_N > 1) ? $clog2(WREG_N) : 1;
  localparam int PROD_W = COUNT_BITS + WEIGHT_W;
  localparam int OUT_W  = (COUNT_BITS > CONN_W) ? COUNT_BITS : CONN_W;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  typedef enum logic [2:0] {
    S_IDLE,
    S_LHS,
    S_RHS,
    S_CMP,
    S_UPD,
    S_DONE
  } state_t;

  state_t                state;
  logic [SC_W-1:0]       server_count;
  logic [WEIGHT_W-1:0]   weights [WREG_N];
  logic [COUNT_BITS-1:0] counts [SERVERS];
  logic                  op;
  logic [SRV_W-1:0]      idx;
  logic [IDX_W-1:0]      best;
  logic [IDX_W-1:0]      cur;
  logic [PROD_W-1:0]     lhs;
  logic [PROD_W-1:0]     rhs;
  rsp_word_t             res;

  logic [WIDE_W-1:0]     sc_wide;
  logic [WIDE_W-1:0]     n_wide;
  logic [IDX_W-1:0]      a_idx;
  logic [IDX_W-1:0]      b_idx;
  logic [WEIGHT_W-1:0]   w_raw;
  logic [WEIGHT_W-1:0]   w_eff;
  logic [PROD_W-1:0]     prod;
  logic                  last_server;
  logic [WIDE_W-1:0]     idx_wide;
  logic                  idx_active;
  logic                  idx_exists;
  logic [IDX_W-1:0]      tgt;
  logic [COUNT_BITS-1:0] tgt_count;
  logic [COUNT_BITS-1:0] new_count;
  logic                  count_we;
  logic [COUNT_BITS-1:0] res_count;
  logic [STATUS_W-1:0]   res_status;
  logic [OUT_W-1:0]      res_count_wide;
  logic [WIDE_W-1:0]     res_server_wide;
  logic [CFG_IDX_W-1:0]  cfg_slot;

  assign req_ready = (state == S_IDLE);

  always_comb begin
    sc_wide = WIDE_W'(server_count);
    if (sc_wide == '0) begin
      n_wide = WIDE_W'(1);
    end else if (sc_wide > WIDE_W'(SERVERS)) begin
      n_wide = WIDE_W'(SERVERS);
    end else begin
      n_wide = sc_wide;
    end
  end

  assign a_idx = (state == S_LHS) ? cur : best;
  assign b_idx = (state == S_LHS) ? best : cur;

  always_comb begin
    if (WIDE_W'(b_idx) < WIDE_W'(WREG_N)) begin
      w_raw = weights[b_idx[WI_W-1:0]];
    end else begin
      w_raw = WEIGHT_W'(1);
    end
    w_eff = (w_raw == '0) ? WEIGHT_W'(1) : w_raw;
  end

  assign prod        = PROD_W'(counts[a_idx]) * PROD_W'(w_eff);
  assign last_server = ((WIDE_W'(cur) + WIDE_W'(1)) == n_wide);

  always_comb begin
    idx_wide   = WIDE_W'(idx);
    idx_active = (idx_wide < n_wide);
    idx_exists = (idx_wide < WIDE_W'(SERVERS));
    tgt        = (op == OP_CLOSE) ? idx_wide[IDX_W-1:0] : best;
    tgt_count  = counts[tgt];
    new_count  = tgt_count;
    count_we   = 1'b0;
    res_count  = tgt_count;
    res_status = ST_OK;
    if (op == OP_OPEN) begin
      if (tgt_count == COUNT_MAX) begin
        res_status = ST_SATURATED;
      end else begin
        new_count = tgt_count + COUNT_BITS'(1);
        count_we  = 1'b1;
        res_count = new_count;
      end
    end else if (!idx_active) begin
      res_status = ST_IDLE_ERR;
      res_count  = idx_exists ? tgt_count : '0;
    end else if (tgt_count == '0) begin
      res_status = ST_IDLE_ERR;
    end else begin
      new_count = tgt_count - COUNT_BITS'(1);
      count_we  = 1'b1;
      res_count = new_count;
    end
    res_count_wide  = OUT_W'(res_count);
    res_server_wide = (op == OP_CLOSE) ? idx_wide : WIDE_W'(best);
  end

  assign cfg_slot = cfg_index - REG_WEIGHT_0;

  always_ff @(posedge clk) begin
    if (rst) begin
      server_count <= SC_W'(4);
      for (int k = 0; k < WREG_N; k++) begin
        weights[k] <= WEIGHT_W'(1);
      end
    end else if (cfg_we) begin
      if (cfg_index == REG_SERVER_COUNT) begin
        server_count <= cfg_data[SC_W-1:0];
      end else if (cfg_index <= REG_WEIGHT_LAST) begin
        if (32'(cfg_slot) < WREG_N) begin
          weights[cfg_slot[WI_W-1:0]] <= cfg_data[WEIGHT_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
      best      <= '0;
      cur       <= '0;
      for (int k = 0; k < SERVERS; k++) begin
        counts[k] <= '0;
      end
    end else begin
      if (rsp_ready && state != S_DONE) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            op   <= req.op;
            idx  <= req.server_index;
            best <= '0;
            cur  <= IDX_W'(1);
            if (req.op == OP_CLOSE || n_wide == WIDE_W'(1)) begin
              state <= S_UPD;
            end else begin
              state <= S_LHS;
            end
          end
        end
        S_LHS: begin
          lhs   <= prod;
          state <= S_RHS;
        end
        S_RHS: begin
          rhs   <= prod;
          state <= S_CMP;
        end
        S_CMP: begin
          if (lhs < rhs) begin
            best <= cur;
          end
          if (last_server) begin
            state <= S_UPD;
          end else begin
            cur   <= cur + IDX_W'(1);
            state <= S_LHS;
          end
        end
        S_UPD: begin
          if (count_we) begin
            counts[tgt] <= new_count;
          end
          res.server      <= res_server_wide[SRV_W-1:0];
          res.connections <= res_count_wide[CONN_W-1:0];
          res.status      <= res_status;
          state           <= S_DONE;
        end
        S_DONE: begin
          if (!rsp_valid || rsp_ready) begin
            rsp       <= res;
            rsp_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- verif/tb_weighted_least_connections_picker_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Weighted least-connections picker testbench
// Drives open and close requests through the picker under random gaps and
// output stalls, tracks the connection counts and weights on its own side,
// and compares every response word field by field. It covers tie-breaking,
// out-of-range server counts, zero weights, and closes on idle or absent
// servers.
// ----------------------------------------------------------------------------
module tb_weighted_least_connections_picker_unit;
  import wlc_pkg::*;

  localparam int SERVERS     = DEF_SERVERS;
  localparam int PHASE_WORDS = 150;
  localparam int PHASES      = 5;
  localparam int HOLD_AT     = 200;
  localparam int LONG_HOLD   = 80;
  localparam int QUIET_LIMIT = 1000;
  localparam int END_SETTLE  = 40;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_word_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_word_t rsp;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  req_word_t pending_reqs[$];
  rsp_word_t expected_words[$];

  logic [CONN_W-1:0] conn_count [SERVERS];
  logic [SC_W-1:0] server_count_cfg;
  logic [WEIGHT_W-1:0] weight_cfg [SERVERS];

  logic idle_on = 1'b1;
  int gap_left = 0;
  int stall_left = 0;
  int words_seen = 0;
  int quiet_cycles = 0;
  int mismatches = 0;

  weighted_least_connections_picker_unit u_dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp(rsp),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  function automatic logic [WEIGHT_W-1:0] eff_weight(int s);
    return (weight_cfg[s] == '0) ? WEIGHT_W'(1) : weight_cfg[s];
  endfunction

  // Updates the tracked counts for one accepted request and returns the word
  // the picker must answer with.
  function automatic rsp_word_t serve_request(req_word_t w);
    rsp_word_t r;
    int n;
    int best;
    logic [CONN_W+WEIGHT_W-1:0] lhs;
    logic [CONN_W+WEIGHT_W-1:0] rhs;
    n = (server_count_cfg == '0) ? 1 : int'(server_count_cfg);
    if (n > SERVERS) n = SERVERS;
    r = '0;
    r.status = ST_OK;
    if (w.op == OP_OPEN) begin
      best = 0;
      for (int i = 1; i < n; i++) begin
        lhs = conn_count[i] * eff_weight(best);
        rhs = conn_count[best] * eff_weight(i);
        if (lhs < rhs) best = i;
      end
      if (conn_count[best] == {CONN_W{1'b1}}) begin
        r.status = ST_SATURATED;
      end else begin
        conn_count[best] = conn_count[best] + 1'b1;
      end
      r.server = SRV_W'(best);
      r.connections = conn_count[best];
    end else begin
      r.server = w.server_index;
      if (int'(w.server_index) >= n) begin
        r.status = ST_IDLE_ERR;
        r.connections = conn_count[w.server_index];
      end else if (conn_count[w.server_index] == '0) begin
        r.status = ST_IDLE_ERR;
        r.connections = '0;
      end else begin
        conn_count[w.server_index] = conn_count[w.server_index] - 1'b1;
        r.connections = conn_count[w.server_index];
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic add_request(logic op, logic [SRV_W-1:0] idx);
    req_word_t w;
    w.op = op;
    w.server_index = idx;
    pending_reqs.push_back(w);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    if (idx == REG_SERVER_COUNT) begin
      server_count_cfg = data[SC_W-1:0];
    end else if (idx >= REG_WEIGHT_0 && idx <= REG_WEIGHT_LAST) begin
      weight_cfg[idx - REG_WEIGHT_0] = data;
    end
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_reqs.size() != 0 || req_valid || expected_words.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  always @(posedge clk) begin : req_side
    logic busy;
    if (rst) begin
      req_valid <= 1'b0;
      req <= '0;
      gap_left = 0;
    end else begin
      busy = req_valid;
      if (req_valid && req_ready) begin
        expected_words.push_back(serve_request(req));
        gap_left = idle_on ? $urandom_range(0, 5) : 0;
        busy = 1'b0;
      end
      if (!busy) begin
        if (gap_left > 0) begin
          gap_left--;
          req_valid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          req <= pending_reqs.pop_front();
          req_valid <= 1'b1;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : rsp_side
    rsp_word_t want;
    if (rst) begin
      rsp_ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (expected_words.size() == 0) begin
          report_mismatch($sformatf("unexpected word %p", rsp));
        end else begin
          want = expected_words.pop_front();
          if (rsp.server !== want.server)
            report_mismatch($sformatf("server %0d, want %0d", rsp.server, want.server));
          if (rsp.connections !== want.connections)
            report_mismatch($sformatf("connections %0d, want %0d",
                                      rsp.connections, want.connections));
          if (rsp.status !== want.status)
            report_mismatch($sformatf("status %0d, want %0d", rsp.status, want.status));
        end
        words_seen++;
        // One long hold-off so the picker backs up and stalls its input.
        if (words_seen == HOLD_AT) stall_left = LONG_HOLD;
        else stall_left = idle_on ? $urandom_range(0, 5) : 0;
      end
      if (stall_left > 0) begin
        stall_left--;
        rsp_ready <= 1'b0;
      end else begin
        rsp_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    logic [SC_W-1:0] sc;
    logic [WEIGHT_W-1:0] wv [SERVERS];
    server_count_cfg = SC_W'(SERVERS);
    for (int i = 0; i < SERVERS; i++) begin
      weight_cfg[i] = WEIGHT_W'(1);
      conn_count[i] = '0;
    end
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: equal weights, so ties fall to the lowest index.
    repeat (5) add_request(OP_OPEN, 2'd0);
    add_request(OP_CLOSE, 2'd3);
    add_request(OP_CLOSE, 2'd3);
    add_request(OP_CLOSE, 2'd1);
    wait_drained();

    // Two servers, upper data bits set, a zero weight; closes past the count.
    write_reg(REG_SERVER_COUNT, {5'b11111, 3'd2});
    write_reg(REG_WEIGHT_0, 8'd255);
    write_reg(REG_WEIGHT_0 + 3'd1, 8'd0);
    add_request(OP_CLOSE, 2'd2);
    add_request(OP_CLOSE, 2'd3);
    add_request(OP_OPEN, 2'd3);
    add_request(OP_OPEN, 2'd1);
    wait_drained();

    // A zero server count acts as one server.
    write_reg(REG_SERVER_COUNT, 8'd0);
    add_request(OP_OPEN, 2'd2);
    add_request(OP_CLOSE, 2'd1);
    wait_drained();

    // A count above the server total acts as all servers; writes past the
    // last weight register must change nothing.
    write_reg(REG_SERVER_COUNT, 8'd7);
    write_reg(REG_WEIGHT_0, 8'd0);
    write_reg(REG_WEIGHT_0 + 3'd2, 8'd255);
    write_reg(REG_WEIGHT_LAST, 8'd128);
    for (int r = REG_WEIGHT_LAST + 1; r < (1 << CFG_IDX_W); r++)
      write_reg(CFG_IDX_W'(r), 8'd0);
    add_request(OP_OPEN, 2'd0);
    add_request(OP_OPEN, 2'd3);
    add_request(OP_CLOSE, 2'd0);
    add_request(OP_CLOSE, 2'd2);
    add_request(OP_OPEN, 2'd1);
    add_request(OP_CLOSE, 2'd1);
    wait_drained();

    for (int p = 0; p < PHASES; p++) begin
      for (int i = 0; i < SERVERS; i++) wv[i] = WEIGHT_W'($urandom_range(0, 255));
      case (p)
        0: begin
          sc = 3'd4;
          for (int i = 0; i < SERVERS; i++) wv[i] = 8'd255;
        end
        1: begin
          sc = 3'd3;
          wv[0] = 8'd1;
          wv[1] = 8'd2;
          wv[2] = 8'd0;
          wv[3] = 8'd255;
        end
        2: sc = SC_W'($urandom_range(0, 7));
        3: sc = 3'd7;
        default: begin
          sc = SC_W'($urandom_range(1, 4));
          wv[$urandom_range(0, SERVERS - 1)] = 8'd255;
        end
      endcase
      write_reg(REG_SERVER_COUNT, {5'($urandom_range(0, 31)), sc});
      for (int i = 0; i < SERVERS; i++) write_reg(REG_WEIGHT_0 + CFG_IDX_W'(i), wv[i]);
      idle_on = (p % 2 == 0);
      for (int k = 0; k < PHASE_WORDS; k++)
        add_request(($urandom_range(0, 99) < 55) ? OP_OPEN : OP_CLOSE,
                    SRV_W'($urandom_range(0, 3)));
      wait_drained();
    end

    repeat (END_SETTLE) @(negedge clk);
    if (mismatches == 0 && expected_words.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- weighted_least_connections_picker_unit.f -----
rtl/wlc_pkg.sv
rtl/weighted_least_connections_picker_unit.sv
verif/tb_weighted_least_connections_picker_unit.sv
